// ===== src/assert_macros.svh =====
// Assertion helpers used by sine_ramp_fold_modulo_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRFM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/srfm_pkg.sv =====
package srfm_pkg;

   // Block configuration.
   localparam int NUM_CHANNELS  = 16;
   localparam int FRACTION_BITS = 11;

   // Field widths.
   localparam int CH_W  = 4;
   localparam int V_W   = 16;
   localparam int REQ_W = ((CH_W + 6 * V_W + 7) / 8) * 8;
   localparam int RSP_W = ((CH_W + V_W + 7) / 8) * 8;

   // Ramp division by NUM_CHANNELS - 1 through a reciprocal.
   localparam int RAMP_DIV    = NUM_CHANNELS - 1;
   localparam int RECIP_SHIFT = 26;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + RAMP_DIV - 1) / RAMP_DIV);
   localparam int PROD_W = V_W + CH_W + 2;
   localparam int X_W    = PROD_W + 1;
   localparam int ARG_W  = X_W + V_W;

   // Phase: argument times 1/(2 pi) in Q32, split into two 15-bit halves.
   localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
   localparam logic [15:0] INV_LO = {1'b0, INV_TWO_PI_Q32[14:0]};
   localparam logic [15:0] INV_HI = {1'b0, INV_TWO_PI_Q32[29:15]};
   localparam int PP_W = ARG_W + 16;
   localparam int PH_W = 2 * FRACTION_BITS + 32;

   // Sine polynomial in unsigned Q30.
   localparam logic [31:0] ONE_Q30 = 32'd1073741824;
   localparam logic [31:0] SIN_A9  = 32'd172272;
   localparam logic [31:0] HORNER_COEF [0:3] = '{
      32'd5026995, 32'd85569305, 32'd693598667, 32'd1686629713
   };
   localparam int S_W = FRACTION_BITS + 2;

   // Dividend and modulus.
   localparam int SUM_W = ((S_W > V_W) ? S_W : V_W) + 1;
   localparam int D_W   = SUM_W + V_W;
   localparam int DQ_W  = D_W - FRACTION_BITS;
   localparam int M_W   = V_W;
   localparam logic [M_W-1:0] ZERO_MOD = M_W'(2);

   // Data carried beside the sine pipeline.
   typedef struct packed {
      logic                   valid;
      logic [CH_W-1:0]        channel;
      logic signed [V_W-1:0]  offset;
      logic signed [V_W-1:0]  scale;
      logic signed [V_W-1:0]  modulus;
   } side_type;

   // State handed from one remainder cell to the next.
   typedef struct packed {
      logic             valid;
      logic [CH_W-1:0]  channel;
      logic             neg;
      logic [M_W-1:0]   modulus;
      logic [M_W-1:0]   rem;
      logic [DQ_W-1:0]  dq;
   } cell_type;

   // Q30 product rounded half up.
   function automatic logic [31:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] prod;
      prod = 64'(a) * 64'(b) + (64'd1 << 29);
      return prod[61:30];
   endfunction

endpackage

// ===== src/srfm_cell.sv =====
module srfm_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  srfm_pkg::cell_type cell_in,
   output srfm_pkg::cell_type cell_out
);
   import srfm_pkg::*;

   logic [M_W:0] shifted;
   cell_type     cell_data_in;

   // One restoring step: bring in the next dividend bit and subtract if it fits.
   always_comb begin
      shifted      = {cell_in.rem, cell_in.dq[DQ_W-1]};
      cell_data_in = cell_in;
      cell_data_in.dq = {cell_in.dq[DQ_W-2:0], 1'b0};
      if (shifted >= {1'b0, cell_in.modulus}) begin
         cell_data_in.rem = M_W'(shifted - {1'b0, cell_in.modulus});
      end else begin
         cell_data_in.rem = shifted[M_W-1:0];
      end
   end

   logic cell_valid_ff;
   cell_type cell_data_ff;

   // Valid resets; the payload only follows the pipeline enable.
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_valid_ff <= 1'b0;
      end else if (en) begin
         cell_valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_data_ff <= cell_data_in;
      end
   end

   always_comb begin
      cell_out       = cell_data_ff;
      cell_out.valid = cell_valid_ff;
   end

endmodule

// ===== src/srfm_sine.sv =====
module srfm_sine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic [30:0]                          t_in,
   input  logic [1:0]                           quad_in,
   input  srfm_pkg::side_type                   side_in,
   output logic signed [srfm_pkg::S_W-1:0]      sine_out,
   output srfm_pkg::side_type                   side_out
);
   import srfm_pkg::*;

   localparam logic [31:0] ROUND_HALF = 32'd1 << (29 - FRACTION_BITS);

   // Stage registers; index 0 holds t squared, each Horner step adds one.
   logic [31:0] h_p_ff    [0:4];
   logic [31:0] h_t_ff    [0:4];
   logic [31:0] h_t2_ff   [0:4];
   logic [1:0]  h_quad_ff [0:4];
   side_type    h_side_ff [0:4];

   logic [31:0] m_p_ff;
   logic [1:0]  m_quad_ff;
   side_type    m_side_ff;

   logic signed [S_W-1:0] sine_ff;
   side_type              out_side_ff;

   // Square of the reduced angle.
   always_ff @(posedge clock) begin
      if (reset) begin
         h_side_ff[0] <= '0;
      end else if (en) begin
         h_side_ff[0] <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_t_ff[0]    <= {1'b0, t_in};
         h_t2_ff[0]   <= mul_q30({1'b0, t_in}, {1'b0, t_in});
         h_p_ff[0]    <= SIN_A9;
         h_quad_ff[0] <= quad_in;
      end
   end

   // Horner steps, one coefficient per stage.
   for (genvar k = 0; k < 4; k++) begin : g_horner
      always_ff @(posedge clock) begin
         if (reset) begin
            h_side_ff[k+1] <= '0;
         end else if (en) begin
            h_side_ff[k+1] <= h_side_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            h_p_ff[k+1]    <= HORNER_COEF[k] - mul_q30(h_t2_ff[k], h_p_ff[k]);
            h_t_ff[k+1]    <= h_t_ff[k];
            h_t2_ff[k+1]   <= h_t2_ff[k];
            h_quad_ff[k+1] <= h_quad_ff[k];
         end
      end
   end

   // Final multiplication by t.
   always_ff @(posedge clock) begin
      if (reset) begin
         m_side_ff <= '0;
      end else if (en) begin
         m_side_ff <= h_side_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_p_ff    <= mul_q30(h_t_ff[4], h_p_ff[4]);
         m_quad_ff <= h_quad_ff[4];
      end
   end

   // Clamp to one, round to the output fraction and apply the quadrant sign.
   logic [31:0]           p_clamp;
   logic [31:0]           p_round;
   logic signed [S_W-1:0] mag;

   always_comb begin
      p_clamp = (m_p_ff > ONE_Q30) ? ONE_Q30 : m_p_ff;
      p_round = (p_clamp + ROUND_HALF) >> (30 - FRACTION_BITS);
      mag     = $signed(p_round[S_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_side_ff <= '0;
      end else if (en) begin
         out_side_ff <= m_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sine_ff <= m_quad_ff[1] ? -mag : mag;
      end
   end

   assign sine_out = sine_ff;
   assign side_out = out_side_ff;

endmodule

// ===== src/sine_ramp_fold_modulo_unit.sv =====
// Sine ramp fold with truncating modulo, one channel per item.
// The request channel (req_) carries one channel index with the ramp ends,
// the sine multiplier, offset, scale and modulus of that channel. The
// response channel (rsp_) returns the channel index and the folded value.
// All voltages are signed with 11 fractional bits.
// When the output is not stalled, one item is taken every cycle: the datapath
// is a fixed pipeline of 37 registers made of the ramp and phase stages, the
// sine polynomial stages, the dividend stage, the chain input register, a
// chain of 22 remainder cells that each resolve one dividend bit, and the
// output register. Reset clears every valid bit; no result is pending after it.
// When the receiver stalls a waiting result, the whole pipeline holds and
// req_tready drops; while the output register is empty or being read, the
// pipeline keeps moving and gaps between items pass through unchanged.
`include "assert_macros.svh"

module sine_ramp_fold_modulo_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // channel, start_voltage, end_voltage, freq_mult, offset_voltage,
   // scale_factor, modulus_voltage
   input  logic [srfm_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // channel_out, channel_value
   output logic [srfm_pkg::RSP_W-1:0]  rsp_tdata
);
   import srfm_pkg::*;

   localparam int NUM_CELLS = DQ_W;

   logic en;
   logic rsp_tvalid_ff;

   // The pipeline moves whenever the output register can take a result.
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   // Request fields.
   logic [CH_W-1:0]       in_channel;
   logic signed [V_W-1:0] in_start, in_end, in_fmul, in_offset, in_scale, in_mod;
   side_type              in_side;

   always_comb begin
      in_channel = req_tdata[CH_W-1:0];
      in_start   = $signed(req_tdata[CH_W+V_W-1:CH_W]);
      in_end     = $signed(req_tdata[CH_W+2*V_W-1:CH_W+V_W]);
      in_fmul    = $signed(req_tdata[CH_W+3*V_W-1:CH_W+2*V_W]);
      in_offset  = $signed(req_tdata[CH_W+4*V_W-1:CH_W+3*V_W]);
      in_scale   = $signed(req_tdata[CH_W+5*V_W-1:CH_W+4*V_W]);
      in_mod     = $signed(req_tdata[CH_W+6*V_W-1:CH_W+5*V_W]);
      in_side.valid   = req_tvalid;
      in_side.channel = in_channel;
      in_side.offset  = in_offset;
      in_side.scale   = in_scale;
      in_side.modulus = in_mod;
   end

   // Stage 1: channel index times the ramp span.
   side_type                 s1_side_ff;
   logic signed [V_W-1:0]    s1_start_ff, s1_fmul_ff;
   logic signed [PROD_W-1:0] s1_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff <= '0;
      end else if (en) begin
         s1_side_ff <= in_side;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_start_ff <= in_start;
         s1_fmul_ff  <= in_fmul;
         s1_prod_ff  <= PROD_W'($signed({1'b0, in_channel}) *
                                (PROD_W'(in_end) - PROD_W'(in_start)));
      end
   end

   // Stage 2: truncating division by the ramp length, then the ramp point.
   logic [PROD_W-1:0]             prod_mag;
   logic [PROD_W+RECIP_W-1:0]     quot_full;
   logic signed [X_W-1:0]         quot;
   logic signed [X_W-1:0]         x_in;

   always_comb begin
      prod_mag  = s1_prod_ff[PROD_W-1] ? PROD_W'(-s1_prod_ff) : PROD_W'(s1_prod_ff);
      quot_full = (PROD_W+RECIP_W)'(prod_mag) * (PROD_W+RECIP_W)'(RECIP);
      quot      = $signed({1'b0, quot_full[RECIP_SHIFT +: PROD_W]});
      x_in      = X_W'(s1_start_ff) + (s1_prod_ff[PROD_W-1] ? -quot : quot);
   end

   side_type              s2_side_ff;
   logic signed [X_W-1:0] s2_x_ff;
   logic signed [V_W-1:0] s2_fmul_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_side_ff <= '0;
      end else if (en) begin
         s2_side_ff <= s1_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_x_ff    <= x_in;
         s2_fmul_ff <= s1_fmul_ff;
      end
   end

   // Stage 3: sine argument with doubled fraction.
   side_type                s3_side_ff;
   logic signed [ARG_W-1:0] s3_arg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_side_ff <= '0;
      end else if (en) begin
         s3_side_ff <= s2_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_arg_ff <= ARG_W'(s2_fmul_ff) * ARG_W'(s2_x_ff);
      end
   end

   // Stage 4: partial products of the argument and 1/(2 pi).
   side_type               s4_side_ff;
   logic signed [PP_W-1:0] s4_plo_ff, s4_phi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_side_ff <= '0;
      end else if (en) begin
         s4_side_ff <= s3_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_plo_ff <= PP_W'(s3_arg_ff) * PP_W'($signed(INV_LO));
         s4_phi_ff <= PP_W'(s3_arg_ff) * PP_W'($signed(INV_HI));
      end
   end

   // Stage 5: phase in turns, quadrant and mirrored angle.
   logic [PH_W-1:0] phase_full;
   logic [31:0]     phase;
   logic [30:0]     t_in;

   always_comb begin
      phase_full = {PH_W'(s4_phi_ff) << 15} + PH_W'(s4_plo_ff);
      phase      = phase_full[PH_W-1 -: 32];
      t_in       = phase[30] ? 31'(ONE_Q30 - {2'b00, phase[29:0]}) : {1'b0, phase[29:0]};
   end

   side_type    s5_side_ff;
   logic [30:0] s5_t_ff;
   logic [1:0]  s5_quad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_side_ff <= '0;
      end else if (en) begin
         s5_side_ff <= s4_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_t_ff    <= t_in;
         s5_quad_ff <= phase[31:30];
      end
   end

   // Sine polynomial pipeline.
   logic signed [S_W-1:0] sine_value;
   side_type              sine_side;

   srfm_sine u_sine (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .t_in     (s5_t_ff),
      .quad_in  (s5_quad_ff),
      .side_in  (s5_side_ff),
      .sine_out (sine_value),
      .side_out (sine_side)
   );

   // Dividend: offset plus sine, times scale.
   side_type              sd_side_ff;
   logic signed [D_W-1:0] sd_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_side_ff <= '0;
      end else if (en) begin
         sd_side_ff <= sine_side;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_d_ff <= D_W'(SUM_W'(sine_side.offset) + SUM_W'(sine_value)) *
                    D_W'(sine_side.scale);
      end
   end

   // Magnitudes of dividend and modulus for the remainder chain.
   logic [D_W-1:0] d_mag;
   logic [M_W-1:0] mod_mag;
   cell_type       cm_in;

   always_comb begin
      d_mag   = sd_d_ff[D_W-1] ? D_W'(-sd_d_ff) : D_W'(sd_d_ff);
      mod_mag = sd_side_ff.modulus[V_W-1] ? M_W'(-sd_side_ff.modulus)
                                          : M_W'(sd_side_ff.modulus);
      cm_in.valid   = sd_side_ff.valid;
      cm_in.channel = sd_side_ff.channel;
      cm_in.neg     = sd_d_ff[D_W-1];
      cm_in.modulus = (mod_mag == '0) ? ZERO_MOD : mod_mag;
      cm_in.rem     = '0;
      cm_in.dq      = d_mag[D_W-1:FRACTION_BITS];
   end

   cell_type chain [0:NUM_CELLS];

   always_ff @(posedge clock) begin
      if (reset) begin
         chain[0] <= '0;
      end else if (en) begin
         chain[0] <= cm_in;
      end
   end

   // Remainder cells, one dividend bit each.
   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      srfm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cell_in  (chain[k]),
         .cell_out (chain[k+1])
      );
   end

   // Output register with the sign of the dividend.
   logic [CH_W-1:0] rsp_channel_ff;
   logic [V_W-1:0]  rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= chain[NUM_CELLS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_channel_ff <= chain[NUM_CELLS].channel;
         rsp_value_ff   <= chain[NUM_CELLS].neg ? V_W'(-chain[NUM_CELLS].rem)
                                                : V_W'(chain[NUM_CELLS].rem);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_W'({rsp_value_ff, rsp_channel_ff});

   // Checks on the datapath and the flow control.
   `SRFM_ASSERT_SAME(a_rem_below_mod, clock, reset, chain[NUM_CELLS].valid,
      chain[NUM_CELLS].rem < chain[NUM_CELLS].modulus, "remainder not below modulus")
   `SRFM_ASSERT_SAME(a_sine_bound, clock, reset, sine_side.valid,
      (sine_value <= $signed(S_W'(1) << FRACTION_BITS)) &&
      (sine_value >= -$signed(S_W'(1) << FRACTION_BITS)),
      "sine value out of range")
   `SRFM_ASSERT_SAME(a_stall_blocks_input, clock, reset, rsp_tvalid_ff && !rsp_tready,
      !req_tready, "item taken while result stalled")
   `SRFM_ASSERT_NEXT(a_zero_scale, clock, reset,
      en && sd_side_ff.valid && (sd_side_ff.scale == '0),
      chain[0].dq == '0, "zero scale gave nonzero dividend")

endmodule
